>>> sv/ossu_pkg.sv
package ossu_pkg;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] key;
        logic [7:0]         position;
    } t_in;

    typedef struct packed {
        logic [7:0] rank;
        t_status    status;
    } t_out;

    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

>>> sv/ossu_cell.sv
module ossu_cell #(
    parameter int KEY_WIDTH = 32,
    parameter int PW        = 9,
    parameter int IDX       = 0
) (
    input  logic                        i_clk,
    input  ossu_pkg::t_cell_ctl         i_ctl,
    input  logic signed [KEY_WIDTH-1:0] i_key,
    input  logic [PW-1:0]               i_pos,
    input  logic [PW-1:0]               i_count,
    input  logic signed [KEY_WIDTH-1:0] i_left_key,
    input  logic                        i_left_gt,
    input  logic signed [KEY_WIDTH-1:0] i_right_key,
    output logic signed [KEY_WIDTH-1:0] o_key,
    output logic                        o_gt
);
    import ossu_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic signed [KEY_WIDTH-1:0] r_key;
    logic signed [KEY_WIDTH-1:0] n_key;
    logic                        occupied;
    logic                        at_or_after;

    assign occupied    = MY_IDX < i_count;
    assign at_or_after = MY_IDX >= i_pos;
    assign o_gt        = occupied && (r_key > i_key);
    assign o_key       = r_key;

    always_comb begin
        n_key = r_key;
        if (i_ctl.ins) begin
            if (o_gt) begin
                n_key = r_key;
            end else if (i_left_gt) begin
                n_key = i_key;
            end else begin
                n_key = i_left_key;
            end
        end else if (i_ctl.del && at_or_after) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

>>> sv/order_statistic_sorted_set_unit.sv
// A command is taken when start is high and busy is low; busy is high for the cycle after start is taken.
// The result strobe o_valid is registered from busy.
// Each command is one compare-and-shift step of the cell row; the rank
// comes from the one-hot insert boundary of that row in the same step.
// Reset (synchronous, active low) empties the store; key cells are not cleared.
// Results cannot be stalled by the receiver.
module order_statistic_sorted_set_unit #(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ossu_pkg::t_in  i_in,
    output logic           o_valid,
    output ossu_pkg::t_out o_out
);
    import ossu_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int RW    = $clog2(CAPACITY);
    localparam int PW    = (CNT_W > 8) ? CNT_W : 8;

    logic                        r_busy;
    t_cmd                        r_cmd;
    logic signed [KEY_WIDTH-1:0] r_key;
    logic [7:0]                  r_pos;
    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;
    logic                        r_valid;
    t_out                        r_out;
    t_out                        n_out;

    logic signed [63:0]          key_ext;
    logic                        accept;
    logic                        full;
    logic                        in_range;
    logic [PW-1:0]               pos_ext;
    logic [PW-1:0]               count_ext;
    t_cell_ctl                   ctl;
    logic [RW-1:0]               rank_idx;

    logic signed [KEY_WIDTH-1:0] cell_key [CAPACITY];
    logic                        cell_gt  [CAPACITY];
    logic                        left_gt  [CAPACITY];

    assign accept    = start && !r_busy;
    assign busy      = r_busy;
    assign key_ext   = 64'(i_in.key);
    assign pos_ext   = PW'(r_pos);
    assign count_ext = PW'(r_count);
    assign full      = r_count == CNT_W'(CAPACITY);
    assign in_range  = pos_ext < count_ext;
    assign ctl.ins   = r_busy && (r_cmd == CMD_INSERT) && !full;
    assign ctl.del   = r_busy && (r_cmd == CMD_DELETE) && in_range;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign left_gt[g] = 1'b1;
        end else begin : g_rest
            assign left_gt[g] = cell_gt[g-1];
        end

        ossu_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .PW        (PW),
            .IDX       (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_key       (r_key),
            .i_pos       (pos_ext),
            .i_count     (count_ext),
            .i_left_key  ((g == 0) ? r_key : cell_key[(g == 0) ? 0 : g-1]),
            .i_left_gt   (left_gt[g]),
            .i_right_key ((g == CAPACITY-1) ? cell_key[g]
                                            : cell_key[(g == CAPACITY-1) ? g : g+1]),
            .o_key       (cell_key[g]),
            .o_gt        (cell_gt[g])
        );
    end

    // insert boundary is one-hot across the row; encode it to a position
    always_comb begin
        rank_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (left_gt[i] && !cell_gt[i]) begin
                rank_idx = rank_idx | RW'(i);
            end
        end
    end

    always_comb begin
        n_count = r_count;
        n_out   = '{rank: 8'd0, status: ST_OK};
        unique case (r_cmd)
            CMD_INSERT: begin
                if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_out.rank = 8'((RW + 8)'(rank_idx));
                    n_count    = r_count + CNT_W'(1);
                end
            end
            CMD_DELETE: begin
                if (!in_range) begin
                    n_out.status = ST_RANGE;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_out.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_busy;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy  <= 1'b0;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_in.cmd;
            r_key <= key_ext[KEY_WIDTH-1:0];
            r_pos <= i_in.position;
        end
        if (r_busy) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

>>> sv/ossu_chk.sv
module ossu_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input ossu_pkg::t_in  i_in,
    input logic           o_valid,
    input ossu_pkg::t_out o_out
);
    import ossu_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted beat");

    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid && !busy)
        else $error("result beat missing after busy cycle");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.status == ST_OK || o_out.status == ST_FULL ||
                     o_out.status == ST_RANGE))
        else $error("illegal status code");

    a_flag_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.status != ST_OK |-> o_out.rank == 8'd0)
        else $error("nonzero rank on flagged beat");

    a_delete_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_in.cmd, 2) == CMD_DELETE |-> o_out.rank == 8'd0
                                                      && o_out.status != ST_FULL)
        else $error("bad result for delete beat");

endmodule

bind order_statistic_sorted_set_unit ossu_chk u_ossu_chk (.*);

>>> sim/order_statistic_sorted_set_unit_tb.sv
`timescale 1ns / 100ps

module order_statistic_sorted_set_unit_tb;

    import ossu_pkg::*;

    localparam int CAPACITY   = 256;
    localparam int KEY_WIDTH  = 32;
    localparam int RAND_BEATS = 600;
    localparam int MAX_GAP    = 40;
    localparam int WDOG_LIMIT = 1000;
    localparam int MAX_REPORT = 10;

    typedef struct {
        t_in  beat;
        bit   typed;
        t_out want;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  i_in    = '0;
    logic busy;
    logic o_valid;
    t_out o_out;

    order_statistic_sorted_set_unit #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    always #1 i_clk = ~i_clk;

    // shadow copy of the sorted multiset
    logic signed [31:0] set_keys [CAPACITY];
    int unsigned        set_size = 0;

    t_out pending_results [$];
    t_row directed_rows [$];

    int mismatches = 0;
    int n_beats    = 0;
    int n_ins      = 0;
    int n_del      = 0;
    int n_full     = 0;
    int n_range    = 0;
    int n_checked  = 0;
    int wdog_count = 0;

    function automatic t_out apply_set_op(t_in b);
        t_out        r;
        int unsigned pos;
        int unsigned i;
        r.rank   = '0;
        r.status = ST_OK;
        if (b.cmd == CMD_INSERT) begin
            if (set_size >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < set_size && $signed(set_keys[pos]) > $signed(b.key))
                    pos++;
                for (i = set_size; i > pos; i--)
                    set_keys[i] = set_keys[i - 1];
                set_keys[pos] = b.key;
                set_size++;
                r.rank = 8'(pos);
            end
        end else begin
            if (b.position >= set_size) begin
                r.status = ST_RANGE;
            end else begin
                for (i = b.position; i + 1 < set_size; i++)
                    set_keys[i] = set_keys[i + 1];
                set_size--;
            end
        end
        return r;
    endfunction

    function automatic void add_row(t_cmd c, logic [31:0] k, logic [7:0] p,
                                    bit typed, logic [7:0] rk, t_status st);
        t_row row;
        row.beat.cmd      = c;
        row.beat.key      = k;
        row.beat.position = p;
        row.typed         = typed;
        row.want.rank     = rk;
        row.want.status   = st;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [31:0] pick_key();
        logic [31:0] k;
        case ($urandom_range(9))
            0, 1, 2, 3: k = $urandom;
            4, 5, 6:    k = 32'(int'($urandom_range(8)) - 4);
            7:          k = 32'h7fffffff;
            8:          k = 32'h80000000;
            default:    k = 32'(int'($urandom_range(200)) - 100);
        endcase
        return k;
    endfunction

    // holds start until the beat is taken, then books its expected result
    task automatic send_beat(t_in b, bit typed, t_out want);
        t_out expd;
        i_in  <= b;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        expd = apply_set_op(b);
        if (typed)
            expd = want;
        pending_results.push_back(expd);
        n_beats++;
        if (b.cmd == CMD_INSERT)
            n_ins++;
        else
            n_del++;
        if (expd.status == ST_FULL)
            n_full++;
        if (expd.status == ST_RANGE)
            n_range++;
    endtask

    task automatic sender_gap(int pct);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && int'($urandom_range(99)) < pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                    $display("unexpected result: rank %0d status %0d",
                             o_out.rank, o_out.status);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_out.rank !== want.rank || o_out.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display("mismatch: expected rank %0d status %0d, got rank %0d status %0d",
                                 want.rank, want.status, o_out.rank, o_out.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            wdog_count <= 0;
        else
            wdog_count <= wdog_count + 1;
        if (wdog_count >= WDOG_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", WDOG_LIMIT);
            $display("order_statistic_sorted_set_unit_tb: FAIL");
            $finish;
        end
    end

    initial begin
        t_in  b;
        t_out none;
        bit   filling;
        int   pct;
        int   roll;
        none = '0;
        filling = 1'b1;

        add_row(CMD_DELETE, 32'h0,        8'd0,   1, 8'd0, ST_RANGE);
        add_row(CMD_DELETE, 32'h0,        8'd255, 1, 8'd0, ST_RANGE);
        add_row(CMD_INSERT, 32'h0,        8'd0,   1, 8'd0, ST_OK);
        add_row(CMD_INSERT, 32'h7fffffff, 8'd0,   1, 8'd0, ST_OK);
        add_row(CMD_INSERT, 32'h80000000, 8'd0,   1, 8'd2, ST_OK);
        add_row(CMD_INSERT, 32'h0,        8'd0,   1, 8'd1, ST_OK);
        add_row(CMD_INSERT, 32'hffffffff, 8'd0,   1, 8'd3, ST_OK);
        add_row(CMD_INSERT, 32'h80000000, 8'd0,   1, 8'd4, ST_OK);
        add_row(CMD_DELETE, 32'h0,        8'd6,   1, 8'd0, ST_RANGE);
        add_row(CMD_DELETE, 32'h0,        8'd5,   1, 8'd0, ST_OK);
        add_row(CMD_DELETE, 32'h0,        8'd0,   1, 8'd0, ST_OK);
        add_row(CMD_INSERT, 32'h7fffffff, 8'hff,  1, 8'd0, ST_OK);
        add_row(CMD_DELETE, 32'hffffffff, 8'hff,  1, 8'd0, ST_RANGE);
        add_row(CMD_INSERT, 32'h1,        8'd0,   0, 8'd0, ST_OK);
        add_row(CMD_INSERT, 32'h7ffffffe, 8'd0,   0, 8'd0, ST_OK);
        add_row(CMD_INSERT, 32'h80000001, 8'd0,   0, 8'd0, ST_OK);
        add_row(CMD_DELETE, 32'h7fffffff, 8'd2,   0, 8'd0, ST_OK);
        add_row(CMD_INSERT, 32'hffffffff, 8'd0,   0, 8'd0, ST_OK);
        add_row(CMD_DELETE, 32'h0,        8'd0,   0, 8'd0, ST_OK);
        add_row(CMD_INSERT, 32'h55555555, 8'haa,  0, 8'd0, ST_OK);
        add_row(CMD_INSERT, 32'haaaaaaaa, 8'h55,  0, 8'd0, ST_OK);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n])
            send_beat(directed_rows[n].beat, directed_rows[n].typed, directed_rows[n].want);

        // insert-heavy until full, then delete-heavy until empty, with noise
        for (int k = 0; k < RAND_BEATS; k++) begin
            pct = (k < RAND_BEATS / 3) ? 0 : (k < 2 * RAND_BEATS / 3) ? 78 : 7;
            if (filling && set_size == CAPACITY && $urandom_range(3) == 0)
                filling = 1'b0;
            else if (!filling && set_size == 0 && $urandom_range(3) == 0)
                filling = 1'b1;
            b.key      = pick_key();
            b.position = 8'($urandom_range(255));
            roll       = $urandom_range(99);
            if ($urandom_range(99) < 10) begin
                b.cmd = t_cmd'($urandom_range(1));
            end else begin
                b.cmd = (filling ? roll < 88 : roll < 12) ? CMD_INSERT : CMD_DELETE;
                if (b.cmd == CMD_DELETE && set_size > 0)
                    b.position = 8'($urandom_range(set_size - 1));
            end
            send_beat(b, 1'b0, none);
            sender_gap(pct);
        end
        start <= 1'b0;

        while (pending_results.size() > 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        $display("%0d commands (%0d inserts, %0d deletes), %0d results checked",
                 n_beats, n_ins, n_del, n_checked);
        $display("flags seen: %0d store full, %0d position out of range; %0d mismatches",
                 n_full, n_range, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("order_statistic_sorted_set_unit_tb: PASS");
        else
            $display("order_statistic_sorted_set_unit_tb: FAIL");
        $finish;
    end

endmodule
